### rtl/sfr_pkg.sv
// Shared constants and byte codes for the scale frame reformatter.
package sfr_pkg;

  // Default geometry
  localparam int unsigned STORE_DEPTH  = 24;
  localparam int unsigned WEIGHT_CHARS = 8;

  // Bytes of a report beyond the weight text: space, unit, space, mode, CR, LF
  localparam int unsigned REPORT_EXTRA = 8;

  // Reports that may wait between front and back
  localparam int unsigned JOB_DEPTH = 2;

  // Line codes
  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h0D;
  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_K     = 8'h4B;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  // Message kinds
  localparam logic KIND_MARKER = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

endpackage

### rtl/sfr_front.sv
// Front end: takes serial bytes, tracks the frame and builds report requests.
module sfr_front
  import sfr_pkg::*;
#(
  parameter int unsigned StoreDepth  = STORE_DEPTH,
  parameter int unsigned WeightChars = WEIGHT_CHARS,
  localparam int unsigned RepMax     = WeightChars + REPORT_EXTRA
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         link_up_i,
  output logic                         job_vld_o,
  output logic [RepMax-1:0][7:0]       job_o
);

  localparam int unsigned PW = $clog2(StoreDepth);

  logic [PW-1:0]                 wp_q, wp_d;
  logic [WeightChars-1:0][7:0]   wt_q, wt_d, wt_now;
  logic [15:0]                   unit_q, unit_d;
  logic [15:0]                   mode_q, mode_d;

  always_comb begin
    wt_now = wt_q;
    for (int k = 0; k < int'(WeightChars); k++) begin
      if (int'(wp_q) == k + 1) begin
        wt_now[k] = rx_byte_i;
      end
    end
  end

  always_comb begin
    wp_d   = wp_q;
    wt_d   = wt_q;
    unit_d = unit_q;
    mode_d = mode_q;
    if (vld_i) begin
      wt_d = wt_now;
      unique case (rx_byte_i)
        CHAR_L:  unit_d = {CHAR_L, CHAR_B};
        CHAR_K:  unit_d = {CHAR_K, CHAR_G};
        CHAR_G:  mode_d = {CHAR_G, CHAR_R};
        CHAR_N:  mode_d = {CHAR_N, CHAR_T};
        default: ;
      endcase
      if (rx_byte_i == START_BYTE) begin
        wp_d = PW'(1);
      end else if (wp_q == PW'(StoreDepth - 1)) begin
        wp_d = '0;
      end else begin
        wp_d = wp_q + PW'(1);
      end
      // end of frame: wipe the weight window and restart the pointer
      if (rx_byte_i == END_BYTE) begin
        wt_d = '0;
        wp_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      wt_q   <= '0;
      unit_q <= '0;
      mode_q <= '0;
    end else begin
      wp_q   <= wp_d;
      wt_q   <= wt_d;
      unit_q <= unit_d;
      mode_q <= mode_d;
    end
  end

  always_comb begin
    for (int k = 0; k < int'(WeightChars); k++) begin
      job_o[k] = wt_now[k];
    end
    job_o[WeightChars + 0] = SPACE_BYTE;
    job_o[WeightChars + 1] = unit_q[15:8];
    job_o[WeightChars + 2] = unit_q[7:0];
    job_o[WeightChars + 3] = SPACE_BYTE;
    job_o[WeightChars + 4] = mode_q[15:8];
    job_o[WeightChars + 5] = mode_q[7:0];
    job_o[WeightChars + 6] = END_BYTE;
    job_o[WeightChars + 7] = LINE_FEED;
  end

  assign job_vld_o = vld_i && (rx_byte_i == END_BYTE) && link_up_i;

endmodule

### rtl/sfr_job_fifo.sv
// Short queue of report requests between the front and back ends.
module sfr_job_fifo
  import sfr_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned CW = $clog2(JOB_DEPTH + 1);

  logic [Width-1:0] mem_q [JOB_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(JOB_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PW'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PW'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

### rtl/sfr_back.sv
// Back end: turns a report request into marker and report bytes.
module sfr_back
  import sfr_pkg::*;
#(
  parameter int unsigned WeightChars = WEIGHT_CHARS,
  localparam int unsigned RepMax     = WeightChars + REPORT_EXTRA
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_vld_i,
  input  logic [RepMax-1:0][7:0] job_i,
  output logic                   job_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [7:0]             out_byte_o,
  output logic                   message_kind_o,
  output logic                   last_of_message_o
);

  localparam int unsigned CW = $clog2(RepMax + 1);
  localparam int unsigned IW = $clog2(RepMax);

  logic [CW-1:0] idx_q, idx_m1;
  logic          out_vld_q;
  logic [7:0]    byte_q, byte_d;
  logic          kind_q, kind_d;
  logic          last_q, last_d;
  logic          adv, take, done;

  assign idx_m1 = idx_q - CW'(1);
  assign adv    = !out_vld_q || pop_i;
  assign take   = adv && job_vld_i;

  always_comb begin
    if (idx_q == '0) begin
      byte_d = START_BYTE;
      kind_d = KIND_MARKER;
      last_d = 1'b1;
      // an empty report leaves only the marker
      done   = (job_i[0] == NUL_BYTE);
    end else begin
      byte_d = job_i[idx_m1[IW-1:0]];
      kind_d = KIND_REPORT;
      if (idx_q == CW'(RepMax)) begin
        last_d = 1'b1;
      end else begin
        last_d = (job_i[idx_q[IW-1:0]] == NUL_BYTE);
      end
      done = last_d;
    end
  end

  assign job_pop_o = take && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (take) begin
      idx_q     <= done ? '0 : idx_q + CW'(1);
      out_vld_q <= 1'b1;
    end else if (adv) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  assign empty_o           = !out_vld_q;
  assign out_byte_o        = byte_q;
  assign message_kind_o    = kind_q;
  assign last_of_message_o = last_q;

endmodule

### rtl/scale_frame_reformatter_top.sv
// Top level of the scale frame reformatter: front end, request queue, back end.
//
// Feed the scale's serial bytes in through push/full, one request per cycle;
// a byte is taken at any clock edge where push is high and full is low, so
// bytes flow at one per cycle while the request queue has room. Byte 0x02 restarts the
// frame, L/K latch the unit (LB/KG), G/N latch the mode (GR/NT), and 0x0D
// closes the frame. On a closing byte taken while link_up is high, the block
// queues one marker message (a single 0x02 byte, kind 0) followed by the
// weight report (kind 1): the weight text held at frame positions 1 to
// WeightChars, space, unit, space, mode, CR, LF, cut at its first zero byte.
// Read results through empty/pop; the oldest waiting byte sits on the result
// ports while empty is low, and last_of_message marks the final byte of each
// message. One closed frame yields between one and WeightChars + 9 result bytes,
// one per cycle from the back end's output register while pop is high. Up to two
// closed frames may wait in the request queue; full rises only while it is
// occupied by both, so the input side stalls only when reports arrive faster
// than the result side drains them. Only the weight window of the frame ring
// is held, since nothing else in the ring is ever reported; the write pointer
// still wraps over the full StoreDepth. Reset clears the frame state and the
// pointers, not the queue storage or the output byte, with no clearing pass.
module scale_frame_reformatter_top
  import sfr_pkg::*;
#(
  parameter int unsigned StoreDepth  = STORE_DEPTH,
  parameter int unsigned WeightChars = WEIGHT_CHARS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte side
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  input  logic       link_up_i,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       message_kind_o,
  output logic       last_of_message_o
);

  localparam int unsigned RepMax = WeightChars + REPORT_EXTRA;

  logic                   in_acc;
  logic                   job_wr;
  logic [RepMax-1:0][7:0] job_wdata;
  logic [RepMax-1:0][7:0] job_rdata;
  logic                   job_empty;
  logic                   job_rd;

  // Hold every byte while the request queue has no room for a report
  assign in_acc = push && !full;

  sfr_front #(
    .StoreDepth  (StoreDepth),
    .WeightChars (WeightChars)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (in_acc),
    .rx_byte_i (rx_byte_i),
    .link_up_i (link_up_i),
    .job_vld_o (job_wr),
    .job_o     (job_wdata)
  );

  sfr_job_fifo #(
    .Width (RepMax * 8)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (job_wdata),
    .rd_i    (job_rd),
    .rdata_o (job_rdata),
    .full_o  (full),
    .empty_o (job_empty)
  );

  // Advance through the head request; drop it once its last byte enters the output register
  sfr_back #(
    .WeightChars (WeightChars)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_vld_i         (!job_empty),
    .job_i             (job_rdata),
    .job_pop_o         (job_rd),
    .pop_i             (pop),
    .empty_o           (empty),
    .out_byte_o        (out_byte_o),
    .message_kind_o    (message_kind_o),
    .last_of_message_o (last_of_message_o)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the scale frame reformatter: stimulus table, random frames, scoreboard.
module tb_top;
  import sfr_pkg::*;

  // Clear window after a closing byte, and the longest report a frame can give
  localparam int unsigned CLEAR_LIMIT      = 20;
  localparam int unsigned REPORT_LEN       = WEIGHT_CHARS + REPORT_EXTRA;
  // Run control
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned MAX_REPORTED     = 10;

  // How the expected messages of a table row are obtained
  typedef enum logic [1:0] {
    EXP_MODEL,   // work them out with the frame predictor
    EXP_NONE,    // no message at all
    EXP_MARKER   // the marker byte alone
  } exp_form_e;

  typedef struct packed {
    logic [7:0] data;
    logic       link;
    exp_form_e  form;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } msg_byte_t;

  logic       clk_i   = 1'b0;
  logic       rst_ni  = 1'b0;
  logic       push    = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'h00;
  logic       link_up = 1'b0;
  logic       empty;
  logic       pop     = 1'b0;
  logic [7:0] out_byte;
  logic       msg_kind;
  logic       msg_last;

  // Predictor state: the frame ring, its write pointer, and the latched letters
  logic [7:0]  ring [STORE_DEPTH];
  int unsigned wr_pos;
  logic [15:0] unit_word;
  logic [15:0] mode_word;

  // Message bytes still to come from the block, oldest first
  msg_byte_t   pending_msgs [$];

  int unsigned error_count   = 0;
  int unsigned sent_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_active   = 1'b0;
  event        long_hold_ev;

  // Directed part: extremes of the byte, every letter code, and the special cases
  stim_row_t dir_rows [23] = '{
    // closing byte straight after reset: empty weight text, so the marker alone
    '{END_BYTE,   1'b1, EXP_MARKER},
    // link down: nothing emitted, store still cleared
    '{END_BYTE,   1'b0, EXP_NONE},
    // unit LB and mode NT latched; weight text holds the byte extremes and is
    // cut at the zero after the closing byte
    '{START_BYTE, 1'b1, EXP_MODEL},
    '{CHAR_L,     1'b0, EXP_MODEL},
    '{CHAR_N,     1'b1, EXP_MODEL},
    '{8'hFF,      1'b0, EXP_MODEL},
    '{8'h80,      1'b1, EXP_MODEL},
    '{8'h7F,      1'b0, EXP_MODEL},
    '{8'h01,      1'b1, EXP_MODEL},
    '{END_BYTE,   1'b1, EXP_MODEL},
    // zero in the first weight position: empty report, marker alone
    '{START_BYTE, 1'b0, EXP_MODEL},
    '{NUL_BYTE,   1'b1, EXP_MODEL},
    '{8'h35,      1'b0, EXP_MODEL},
    '{END_BYTE,   1'b1, EXP_MARKER},
    // unit KG and mode GR latched, then the frame dropped by a down link
    '{START_BYTE, 1'b1, EXP_MODEL},
    '{8'h39,      1'b1, EXP_MODEL},
    '{CHAR_K,     1'b0, EXP_MODEL},
    '{CHAR_G,     1'b1, EXP_MODEL},
    '{END_BYTE,   1'b0, EXP_NONE},
    // short weight text: report cut at the zero after the closing byte
    '{START_BYTE, 1'b1, EXP_MODEL},
    '{8'h2D,      1'b0, EXP_MODEL},
    '{8'h30,      1'b1, EXP_MODEL},
    '{END_BYTE,   1'b1, EXP_MODEL}
  };

  scale_frame_reformatter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte),
    .link_up_i        (link_up),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte),
    .message_kind_o   (msg_kind),
    .last_of_message_o(msg_last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Advance the frame predictor by one accepted byte; queue its messages when asked
  task automatic advance_frame(input logic [7:0] b, input logic link, input bit keep);
    logic [7:0]  report [REPORT_LEN];
    int unsigned len;
    int unsigned top;
    int unsigned idx;
    if (wr_pos >= STORE_DEPTH) wr_pos = 0;
    ring[wr_pos] = b;
    case (b)
      START_BYTE: begin
        ring[0] = START_BYTE;
        wr_pos  = 0;
      end
      CHAR_L:  unit_word = {CHAR_L, CHAR_B};
      CHAR_K:  unit_word = {CHAR_K, CHAR_G};
      CHAR_G:  mode_word = {CHAR_G, CHAR_R};
      CHAR_N:  mode_word = {CHAR_N, CHAR_T};
      default: ;
    endcase
    wr_pos = (wr_pos + 1) % STORE_DEPTH;
    if (b != END_BYTE) return;

    // The weight text is read after the closing byte itself has been stored
    for (idx = 0; idx < WEIGHT_CHARS; idx++) report[idx] = ring[1 + idx];
    report[WEIGHT_CHARS + 0] = SPACE_BYTE;
    report[WEIGHT_CHARS + 1] = unit_word[15:8];
    report[WEIGHT_CHARS + 2] = unit_word[7:0];
    report[WEIGHT_CHARS + 3] = SPACE_BYTE;
    report[WEIGHT_CHARS + 4] = mode_word[15:8];
    report[WEIGHT_CHARS + 5] = mode_word[7:0];
    report[WEIGHT_CHARS + 6] = END_BYTE;
    report[WEIGHT_CHARS + 7] = LINE_FEED;
    len = 0;
    while (len < REPORT_LEN && report[len] != NUL_BYTE) len++;

    // Clear for the next frame; position 0 survives unless the pointer has wrapped onto it
    ring[wr_pos] = NUL_BYTE;
    top = (CLEAR_LIMIT > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : CLEAR_LIMIT;
    for (idx = 1; idx <= top; idx++) ring[idx] = NUL_BYTE;
    wr_pos = 0;

    if (link && keep) begin
      pending_msgs.push_back('{START_BYTE, KIND_MARKER, 1'b1});
      for (idx = 0; idx < len; idx++)
        pending_msgs.push_back('{report[idx], KIND_REPORT, (idx + 1 == len)});
    end
  endtask

  // Offer one byte request; returns at the rising edge that takes it.
  // Starts at a falling edge so that every input changes there.
  task automatic offer_request(input logic [7:0] b, input logic link, input exp_form_e form);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    rx_byte <= b;
    link_up <= link;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_count++;
    // Typed rows still move the predictor state, but their messages are given here
    advance_frame(b, link, form == EXP_MODEL);
    if (form == EXP_MARKER && link)
      pending_msgs.push_back('{START_BYTE, KIND_MARKER, 1'b1});
  endtask

  // Frame with random content: start, weight text, optional letters, close
  task automatic send_scale_frame(input logic close_link);
    int unsigned n_chars;
    int unsigned k;
    logic [7:0]  c;
    offer_request(START_BYTE, 1'($urandom_range(1)), EXP_MODEL);
    n_chars = $urandom_range(0, 9);
    for (k = 0; k < n_chars; k++) begin
      if ($urandom_range(4) == 0) c = 8'($urandom_range(255));
      else if ($urandom_range(5) == 0) c = 8'h2E;
      else c = 8'h30 + 8'($urandom_range(9));
      offer_request(c, 1'($urandom_range(1)), EXP_MODEL);
    end
    if ($urandom_range(3) != 0)
      offer_request($urandom_range(1) ? CHAR_K : CHAR_L, 1'($urandom_range(1)), EXP_MODEL);
    if ($urandom_range(3) != 0)
      offer_request($urandom_range(1) ? CHAR_G : CHAR_N, 1'($urandom_range(1)), EXP_MODEL);
    offer_request(END_BYTE, close_link, EXP_MODEL);
  endtask

  // Long run with no start or close byte, so the write pointer wraps, then close
  task automatic send_wrap_run();
    int unsigned n_bytes;
    logic [7:0]  c;
    n_bytes = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
    repeat (n_bytes) begin
      c = 8'($urandom_range(255));
      if (c == START_BYTE || c == END_BYTE) c = CHAR_K;
      offer_request(c, 1'($urandom_range(1)), EXP_MODEL);
    end
    offer_request(END_BYTE, 1'b1, EXP_MODEL);
  endtask

  // Mix of frames, noise and wrap runs up to the given item count
  task automatic send_random_mix(input int unsigned upto);
    int unsigned pick;
    while (sent_count < upto) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_scale_frame(1'($urandom_range(99) < 85));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4))
          offer_request(8'($urandom_range(255)), 1'($urandom_range(1)), EXP_MODEL);
      end else begin
        send_wrap_run();
      end
    end
  endtask

  // Receiver: drop pop at random, and hold it off entirely during a long stall
  always @(negedge clk_i) begin
    pop <= rst_ni && !hold_active && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver stall, counted here so the sender keeps offering meanwhile
  initial begin
    @(long_hold_ev);
    @(posedge clk_i);
    hold_active = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // Scoreboard: compare each accepted message byte with the oldest expectation
  always @(posedge clk_i) begin
    msg_byte_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_msgs.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTED)
          $display("unexpected result: byte %h kind %0d last %0d", out_byte, msg_kind,
                   msg_last);
      end else begin
        want = pending_msgs.pop_front();
        if (out_byte !== want.data || msg_kind !== want.kind || msg_last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTED)
            $display("mismatch: expected byte %h kind %0d last %0d, got byte %h kind %0d last %0d",
                     want.data, want.kind, want.last, out_byte, msg_kind, msg_last);
        end
      end
    end
  end

  // Guard against a hang anywhere in the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned row;
    for (row = 0; row < STORE_DEPTH; row++) ring[row] = NUL_BYTE;
    wr_pos    = 0;
    unit_word = '0;
    mode_word = '0;

    // Hold reset, then release it on a falling edge
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: sender idles lightly, receiver heavily
    send_idle_pct = 29;
    recv_idle_pct = 74;
    for (row = 0; row < $size(dir_rows); row++)
      offer_request(dir_rows[row].data, dir_rows[row].link, dir_rows[row].form);
    send_random_mix(70);

    // Phase two: the other way round
    send_idle_pct = 74;
    recv_idle_pct = 29;
    send_random_mix(115);

    // Phase three: no idling on either side. Stall the receiver for a long
    // stretch while closed frames pile up, so the request queue fills and
    // full holds the sender back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> long_hold_ev;
    repeat (4) send_scale_frame(1'b1);

    // Pause the sender until every outstanding message byte has come out
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk_i);
    send_random_mix(170);

    @(negedge clk_i);
    push <= 1'b0;

    // Drain, then give the block a while to show any stray result
    while (pending_msgs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_job_fifo.sv
rtl/sfr_back.sv
rtl/scale_frame_reformatter_top.sv
verif/tb_top.sv
